@@ sv/derivative_trend_detector_assert.svh @@
// Assertion macros shared by the checker of the derivative trend detector.
// Each macro expects signals named clk and rst in the scope of its use.
`ifndef DERIVATIVE_TREND_DETECTOR_ASSERT_SVH
`define DERIVATIVE_TREND_DETECTOR_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define DTD_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset.
`define DTD_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ sv/dtd_pkg.sv @@
// Package for the derivative trend detector: widths, codes and the
// command and status structs between controller and datapath. No dependencies.
package dtd_pkg;

  localparam int unsigned DataW   = 32;
  localparam int unsigned ThrW    = 31;
  localparam int unsigned DiffW   = DataW + 1;
  localparam int unsigned DivCntW = 6;
  localparam int unsigned AddrW   = 3;

  // Register index taken from paddr above the byte offset.
  localparam logic [AddrW-3:0] RegAccelThreshold = 1'd0;
  localparam logic [ThrW-1:0]  ThrReset          = ThrW'(655);

  // Input command codes.
  localparam logic CmdPush  = 1'b0;
  localparam logic CmdClear = 1'b1;

  localparam logic [DataW-1:0] IntMax = {1'b0, {(DataW-1){1'b1}}};
  localparam logic [DataW-1:0] IntMin = {1'b1, {(DataW-1){1'b0}}};

  typedef enum logic [1:0] {
    TrendWaiting = 2'd0,
    TrendAccel   = 2'd1,
    TrendPlateau = 2'd2,
    TrendRegress = 2'd3
  } trend_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic capture;
    logic clear_hist;
    logic div_start;
    logic div_sel_curv;
    logic take_rate;
    logic take_curv;
    logic emit;
    logic rate_ok;
    logic curv_ok;
  } dtd_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic have_sample;
    logic have_rate;
    logic dt_pos;
    logic div_done;
  } dtd_status_t;

endpackage

@@ sv/dtd_if.sv @@
// Stream interfaces for the sample and result channels of the detector.
// Depends on dtd_pkg for the field widths.
interface dtd_sample_if
  import dtd_pkg::*;
();
  logic             valid;
  logic             ready;
  logic             cmd;
  logic [DataW-1:0] sample_time;
  logic [DataW-1:0] sample_value;

  modport source (output valid, cmd, sample_time, sample_value, input ready);
  modport sink   (input valid, cmd, sample_time, sample_value, output ready);
endinterface

interface dtd_result_if
  import dtd_pkg::*;
();
  logic             valid;
  logic             ready;
  logic [DataW-1:0] echo_time;
  logic [DataW-1:0] echo_value;
  logic [DataW-1:0] rate;
  logic [DataW-1:0] curvature;
  logic [1:0]       trend;
  logic             flagged;

  modport source (output valid, echo_time, echo_value, rate, curvature, trend, flagged,
                  input ready);
  modport sink   (input valid, echo_time, echo_value, rate, curvature, trend, flagged,
                  output ready);
endinterface

@@ sv/derivative_trend_detector.sv @@
// Derivative trend detector: estimates rate and curvature of a sampled signal.
// Depends on dtd_pkg, dtd_if, dtd_ctrl and dtd_dp.
//
// sample_ch carries transactions of cmd, sample_time and sample_value; cmd
// CmdClear forgets the history and yields no result, CmdPush yields exactly
// one transaction on result_ch. A transaction moves when valid and ready are
// both high at a rising edge of clk.
// One sample is processed at a time. A sample with no usable history or a
// non-positive time step goes from capture through the check state to the
// result register; one that forms only a rate adds one division, and one that
// forms rate and curvature adds two, the two 33-step divisions running in turn
// on the single bit-serial divider. A clear leaves the controller idle, ready
// for the next transaction.
// The result register parts the channels: the next sample is accepted while
// a result still waits, and a finished computation holds until the register
// frees when the receiver stalls.
// Reset (rst, synchronous) empties the result register, forgets the history
// and loads the curvature threshold with its default of 655. The threshold
// lies at APB byte address 0; pready is always high.
module derivative_trend_detector
  import dtd_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  dtd_sample_if.sink         sample_ch,
  dtd_result_if.source       result_ch,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [AddrW-1:0]   paddr,
  input  logic [DataW-1:0]   pwdata,
  output logic [DataW-1:0]   prdata,
  output logic               pready
);

  dtd_cmd_t    cmd;
  dtd_status_t status;

  assign pready = 1'b1;

  dtd_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (sample_ch.valid),
    .in_cmd    (sample_ch.cmd),
    .in_ready  (sample_ch.ready),
    .out_valid (result_ch.valid),
    .out_ready (result_ch.ready),
    .status    (status),
    .cmd       (cmd)
  );

  dtd_dp u_dp (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .status       (status),
    .sample_time  (sample_ch.sample_time),
    .sample_value (sample_ch.sample_value),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .echo_time    (result_ch.echo_time),
    .echo_value   (result_ch.echo_value),
    .rate         (result_ch.rate),
    .curvature    (result_ch.curvature),
    .trend        (result_ch.trend),
    .flagged      (result_ch.flagged)
  );

endmodule

@@ sv/dtd_div.sv @@
// Bit-serial signed divider: 33-bit numerator over a positive 32-bit divisor,
// truncating toward zero and saturating to 32 bits. Depends on dtd_pkg.
module dtd_div
  import dtd_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [DiffW-1:0] num,
  input  logic [DataW-1:0] den,
  output logic             done,
  output logic [DataW-1:0] quot
);

  logic               busy;
  logic [DivCntW-1:0] count;
  logic [DataW-1:0]   divisor;
  logic [DataW-1:0]   rem;
  logic [DiffW-1:0]   quo;
  logic               neg;
  logic [DiffW-1:0]   num_mag;
  logic [DiffW-1:0]   rem_sh;
  logic [DiffW-1:0]   rem_sub;
  logic               fits;

  // The numerator is two's complement; divide its magnitude.
  assign num_mag = num[DiffW-1] ? (~num + DiffW'(1)) : num;

  // One restoring step per cycle.
  assign rem_sh  = {rem, quo[DiffW-1]};
  assign fits    = rem_sh >= {1'b0, divisor};
  assign rem_sub = rem_sh - {1'b0, divisor};

  // Step counter and completion pulse.
  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      done  <= 1'b0;
      count <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy  <= 1'b1;
        count <= '0;
      end else if (busy) begin
        count <= count + DivCntW'(1);
        if (count == DivCntW'(DiffW - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // Remainder and quotient shift registers.
  always_ff @(posedge clk) begin
    if (start) begin
      divisor <= den;
      rem     <= '0;
      quo     <= num_mag;
      neg     <= num[DiffW-1];
    end else if (busy) begin
      rem <= fits ? rem_sub[DataW-1:0] : rem_sh[DataW-1:0];
      quo <= {quo[DiffW-2:0], fits};
    end
  end

  // Restore the sign and clamp to the 32-bit range.
  always_comb begin
    if (neg) begin
      if (quo[DiffW-1] || (quo[DataW-1] && |quo[DataW-2:0])) begin
        quot = IntMin;
      end else begin
        quot = ~quo[DataW-1:0] + DataW'(1);
      end
    end else begin
      if (|quo[DiffW-1:DataW-1]) begin
        quot = IntMax;
      end else begin
        quot = quo[DataW-1:0];
      end
    end
  end

endmodule

@@ sv/dtd_dp.sv @@
// Datapath of the detector: history, threshold register, divider and the
// result register. Depends on dtd_pkg and dtd_div.
module dtd_dp
  import dtd_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  dtd_cmd_t           cmd,
  output dtd_status_t        status,
  input  logic [DataW-1:0]   sample_time,
  input  logic [DataW-1:0]   sample_value,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [AddrW-1:0]   paddr,
  input  logic [DataW-1:0]   pwdata,
  output logic [DataW-1:0]   prdata,
  output logic [DataW-1:0]   echo_time,
  output logic [DataW-1:0]   echo_value,
  output logic [DataW-1:0]   rate,
  output logic [DataW-1:0]   curvature,
  output logic [1:0]         trend,
  output logic               flagged
);

  logic [ThrW-1:0]  curv_limit;
  logic [DataW-1:0] last_time;
  logic [DataW-1:0] last_value;
  logic [DataW-1:0] last_rate;
  logic             have_last_sample;
  logic             have_last_rate;
  logic [DataW-1:0] cur_time;
  logic [DataW-1:0] cur_value;
  logic [DataW-1:0] rate_q;
  logic [DataW-1:0] curv_q;

  logic [DiffW-1:0] dt;
  logic [DiffW-1:0] diff_value;
  logic [DiffW-1:0] diff_rate;
  logic [DiffW-1:0] div_num;
  logic             div_done;
  logic [DataW-1:0] div_quot;
  logic             reg_hit;
  logic             above;
  logic             below;
  trend_t           trend_next;

  // Time step and differences, formed at 33 bits.
  assign dt         = {cur_time[DataW-1], cur_time} - {last_time[DataW-1], last_time};
  assign diff_value = {cur_value[DataW-1], cur_value} - {last_value[DataW-1], last_value};
  assign diff_rate  = {div_quot[DataW-1], div_quot} - {last_rate[DataW-1], last_rate};
  assign div_num    = cmd.div_sel_curv ? diff_rate : diff_value;

  assign status.have_sample = have_last_sample;
  assign status.have_rate   = have_last_rate;
  assign status.dt_pos      = !dt[DiffW-1] && (|dt[DataW-1:0]);
  assign status.div_done    = div_done;

  dtd_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (cmd.div_start),
    .num   (div_num),
    .den   (dt[DataW-1:0]),
    .done  (div_done),
    .quot  (div_quot)
  );

  // Configuration register access.
  assign reg_hit = paddr[AddrW-1:2] == RegAccelThreshold;
  assign prdata  = reg_hit ? {1'b0, curv_limit} : '0;

  // Threshold register and history flags.
  always_ff @(posedge clk) begin
    if (rst) begin
      curv_limit       <= ThrReset;
      have_last_sample <= 1'b0;
      have_last_rate   <= 1'b0;
    end else begin
      if (psel && penable && pwrite && reg_hit) begin
        curv_limit <= pwdata[ThrW-1:0];
      end
      if (cmd.clear_hist) begin
        have_last_sample <= 1'b0;
        have_last_rate   <= 1'b0;
      end else if (cmd.emit) begin
        have_last_sample <= 1'b1;
        if (cmd.rate_ok) begin
          have_last_rate <= 1'b1;
        end
      end
    end
  end

  // Classification of the curvature against the threshold.
  assign above = $signed(curv_q) > $signed({1'b0, curv_limit});
  assign below = $signed(curv_q) < -$signed({1'b0, curv_limit});

  always_comb begin
    if (!cmd.curv_ok) begin
      trend_next = TrendWaiting;
    end else if (above) begin
      trend_next = TrendAccel;
    end else if (below) begin
      trend_next = TrendRegress;
    end else begin
      trend_next = TrendPlateau;
    end
  end

  // Sample capture, quotients, history values and the result register.
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      cur_time  <= sample_time;
      cur_value <= sample_value;
    end
    if (cmd.take_rate) begin
      rate_q <= div_quot;
    end
    if (cmd.take_curv) begin
      curv_q <= div_quot;
    end
    if (cmd.emit) begin
      last_time  <= cur_time;
      last_value <= cur_value;
      if (cmd.rate_ok) begin
        last_rate <= rate_q;
      end
      echo_time  <= cur_time;
      echo_value <= cur_value;
      rate       <= cmd.rate_ok ? rate_q : '0;
      curvature  <= cmd.curv_ok ? curv_q : '0;
      trend      <= trend_next;
      flagged    <= cmd.curv_ok && (above || below);
    end
  end

endmodule

@@ sv/dtd_ctrl.sv @@
// Controller of the detector: sequences capture, the two divisions and the
// hand-over to the result register. Depends on dtd_pkg.
module dtd_ctrl
  import dtd_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  input  logic        in_cmd,
  output logic        in_ready,
  output logic        out_valid,
  input  logic        out_ready,
  input  dtd_status_t status,
  output dtd_cmd_t    cmd
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_CHECK,
    S_DIV_RATE,
    S_DIV_CURV,
    S_EMIT
  } state_t;

  state_t state;
  state_t state_next;
  logic   rate_ok;
  logic   rate_ok_next;
  logic   curv_ok;
  logic   curv_ok_next;
  logic   out_free;

  assign in_ready = state == S_IDLE;
  assign out_free = !out_valid || out_ready;

  // Next state and datapath commands.
  always_comb begin
    state_next   = state;
    rate_ok_next = rate_ok;
    curv_ok_next = curv_ok;
    cmd          = '0;
    cmd.rate_ok  = rate_ok;
    cmd.curv_ok  = curv_ok;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          if (in_cmd == CmdClear) begin
            cmd.clear_hist = 1'b1;
          end else begin
            cmd.capture = 1'b1;
            state_next  = S_CHECK;
          end
        end
      end
      S_CHECK: begin
        rate_ok_next = 1'b0;
        curv_ok_next = 1'b0;
        if (status.have_sample && status.dt_pos) begin
          cmd.div_start = 1'b1;
          state_next    = S_DIV_RATE;
        end else begin
          state_next = S_EMIT;
        end
      end
      S_DIV_RATE: begin
        if (status.div_done) begin
          cmd.take_rate = 1'b1;
          rate_ok_next  = 1'b1;
          if (status.have_rate) begin
            cmd.div_start    = 1'b1;
            cmd.div_sel_curv = 1'b1;
            state_next       = S_DIV_CURV;
          end else begin
            state_next = S_EMIT;
          end
        end
      end
      S_DIV_CURV: begin
        if (status.div_done) begin
          cmd.take_curv = 1'b1;
          curv_ok_next  = 1'b1;
          state_next    = S_EMIT;
        end
      end
      S_EMIT: begin
        if (out_free) begin
          cmd.emit   = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // State, result flags and the output valid.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      rate_ok   <= 1'b0;
      curv_ok   <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      state   <= state_next;
      rate_ok <= rate_ok_next;
      curv_ok <= curv_ok_next;
      if (cmd.emit) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

@@ sv/dtd_checker.sv @@
// Port-level checker for the derivative trend detector, bound to the top level.
// Depends on dtd_pkg and the assertion macros header.
`include "derivative_trend_detector_assert.svh"

module dtd_props
  import dtd_pkg::*;
(
  input logic             clk,
  input logic             rst,
  input logic             out_valid,
  input logic             out_ready,
  input logic [DataW-1:0] echo_time,
  input logic [DataW-1:0] echo_value,
  input logic [DataW-1:0] rate,
  input logic [DataW-1:0] curvature,
  input logic [1:0]       trend,
  input logic             flagged
);

  // A waiting result carries no curvature and is never flagged.
  `DTD_ASSERT_IMP(a_waiting_clean, out_valid && (trend == TrendWaiting), (curvature == '0) && !flagged, "waiting result carries curvature or flag")

  // The flag marks exactly the accelerating and regressing classes.
  `DTD_ASSERT_IMP(a_flag_matches_trend, out_valid, flagged == ((trend == TrendAccel) || (trend == TrendRegress)), "flag disagrees with trend")

  // No result is offered straight after reset.
  `DTD_ASSERT_IMP(a_reset_empty, $past(rst), !out_valid, "result offered after reset")

  // A stalled result holds its transaction.
  `DTD_ASSERT_NXT(a_stall_holds, out_valid && !out_ready, out_valid && $stable(echo_time) && $stable(echo_value) && $stable(rate) && $stable(curvature) && $stable(trend) && $stable(flagged), "stalled result changed")

endmodule

bind derivative_trend_detector dtd_props u_dtd_props (
  .clk        (clk),
  .rst        (rst),
  .out_valid  (result_ch.valid),
  .out_ready  (result_ch.ready),
  .echo_time  (result_ch.echo_time),
  .echo_value (result_ch.echo_value),
  .rate       (result_ch.rate),
  .curvature  (result_ch.curvature),
  .trend      (result_ch.trend),
  .flagged    (result_ch.flagged)
);

@@ bench/dtd_checker.sv @@
`timescale 1ns / 100ps
// Checker for the derivative trend detector: follows the APB threshold writes and
// the sample channel, predicts every result and compares it with the result channel.
// Depends on dtd_pkg and the stream interfaces in dtd_if.
module dtd_checker
  import dtd_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  dtd_sample_if            sample_mon,
  dtd_result_if            result_mon,
  input  logic             psel,
  input  logic             penable,
  input  logic             pwrite,
  input  logic             pready,
  input  logic [AddrW-1:0] paddr,
  input  logic [DataW-1:0] pwdata,
  output int               errors,
  output int               pending
);

  localparam longint SatMax = 64'sd2147483647;
  localparam longint SatMin = -64'sd2147483648;
  localparam int     PrintCap = 100;

  typedef struct {
    logic [DataW-1:0] echo_time;
    logic [DataW-1:0] echo_value;
    logic [DataW-1:0] rate;
    logic [DataW-1:0] curvature;
    trend_t           trend;
    logic             flagged;
  } trend_result_t;

  // Own copy of the detector history and its threshold.
  logic [ThrW-1:0]  threshold;
  logic [DataW-1:0] prev_time;
  logic [DataW-1:0] prev_value;
  logic [DataW-1:0] prev_rate;
  logic             has_sample;
  logic             has_rate;
  trend_result_t    expected_trends[$];

  // Truncating division, clamped to the signed 32-bit range.
  function automatic longint div_clamp(input longint num, input longint den);
    longint q;
    q = num / den;
    if (q > SatMax) begin
      q = SatMax;
    end else if (q < SatMin) begin
      q = SatMin;
    end
    return q;
  endfunction

  task automatic report_mismatch(input string what, input logic [DataW-1:0] got,
                                 input logic [DataW-1:0] want);
    if (errors < PrintCap) begin
      $display("[%0t] mismatch on %s: got %h, expected %h", $time, what, got, want);
    end
    errors++;
  endtask

  // Updates the history for one accepted transaction and queues the result it gives.
  task automatic predict_trend(input logic op, input logic [DataW-1:0] stamp,
                               input logic [DataW-1:0] level);
    trend_result_t res;
    longint        dt;
    longint        rt;
    longint        cv;
    longint        thr;
    if (op == CmdClear) begin
      has_sample = 1'b0;
      has_rate   = 1'b0;
    end else begin
      res.echo_time  = stamp;
      res.echo_value = level;
      res.rate       = '0;
      res.curvature  = '0;
      res.trend      = TrendWaiting;
      res.flagged    = 1'b0;
      if (has_sample) begin
        dt = longint'($signed(stamp)) - longint'($signed(prev_time));
        // A time step that is not positive leaves the rate history alone.
        if (dt > 0) begin
          rt = div_clamp(longint'($signed(level)) - longint'($signed(prev_value)), dt);
          res.rate = rt[DataW-1:0];
          if (has_rate) begin
            cv  = div_clamp(rt - longint'($signed(prev_rate)), dt);
            thr = longint'(threshold);
            res.curvature = cv[DataW-1:0];
            if (cv > thr) begin
              res.trend = TrendAccel;
            end else if (cv < -thr) begin
              res.trend = TrendRegress;
            end else begin
              res.trend = TrendPlateau;
            end
            res.flagged = (cv > thr) || (cv < -thr);
          end
          prev_rate = rt[DataW-1:0];
          has_rate  = 1'b1;
        end
      end
      prev_time  = stamp;
      prev_value = level;
      has_sample = 1'b1;
      expected_trends.insert(expected_trends.size(), res);
    end
  endtask

  // Everything is sampled at the rising edge; inputs only move at the falling edge.
  always @(posedge clk) begin : watch
    trend_result_t want;
    if (rst) begin
      threshold  = ThrReset;
      prev_time  = '0;
      prev_value = '0;
      prev_rate  = '0;
      has_sample = 1'b0;
      has_rate   = 1'b0;
      expected_trends.delete();
      errors  = 0;
      pending = 0;
    end else begin
      // Threshold writes; other register indexes are ignored by the block.
      if (psel && penable && pwrite && pready && paddr[AddrW-1:2] == RegAccelThreshold) begin
        threshold = pwdata[ThrW-1:0];
      end

      if (sample_mon.valid && sample_mon.ready) begin
        predict_trend(sample_mon.cmd, sample_mon.sample_time, sample_mon.sample_value);
      end

      // Each result transaction is held against the oldest prediction.
      if (result_mon.valid && result_mon.ready) begin
        if (expected_trends.size() == 0) begin
          report_mismatch("result with none expected, echo_time", result_mon.echo_time, '0);
        end else begin
          want = expected_trends.pop_front();
          if (result_mon.echo_time !== want.echo_time) begin
            report_mismatch("echo_time", result_mon.echo_time, want.echo_time);
          end
          if (result_mon.echo_value !== want.echo_value) begin
            report_mismatch("echo_value", result_mon.echo_value, want.echo_value);
          end
          if (result_mon.rate !== want.rate) begin
            report_mismatch("rate", result_mon.rate, want.rate);
          end
          if (result_mon.curvature !== want.curvature) begin
            report_mismatch("curvature", result_mon.curvature, want.curvature);
          end
          if (result_mon.trend !== want.trend) begin
            report_mismatch("trend", DataW'(result_mon.trend), DataW'(want.trend));
          end
          if (result_mon.flagged !== want.flagged) begin
            report_mismatch("flagged", DataW'(result_mon.flagged), DataW'(want.flagged));
          end
        end
      end
      pending = expected_trends.size();
    end
  end

endmodule

@@ bench/tb.sv @@
`timescale 1ns / 100ps
// Top of the derivative trend detector bench: clock, reset, sample and APB stimulus,
// random result stalls and the verdict. Depends on dtd_pkg, dtd_if and dtd_checker.
module tb;
  import dtd_pkg::*;

  localparam int unsigned       CycleLimit  = 1000000;
  localparam int                DrainCycles = 100;
  localparam int                LongHold    = 400;
  localparam int                Segments    = 12;
  localparam int                SegmentLen  = 104;
  localparam logic [AddrW-3:0]  RegUnmapped = 1'd1;

  logic             clk;
  logic             rst;
  logic             psel;
  logic             penable;
  logic             pwrite;
  logic [AddrW-1:0] paddr;
  logic [DataW-1:0] pwdata;
  logic [DataW-1:0] prdata;
  logic             pready;
  int               errors;
  int               pending;

  // Idle chances in percent, the long stall request and the random walk of samples.
  int               send_idle_pct;
  int               recv_idle_pct;
  logic             hold_request;
  logic [DataW-1:0] gen_time;
  logic [DataW-1:0] gen_value;

  dtd_sample_if sample_bus ();
  dtd_result_if result_bus ();

  derivative_trend_detector u_top (
    .clk       (clk),
    .rst       (rst),
    .sample_ch (sample_bus),
    .result_ch (result_bus),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready)
  );

  dtd_checker u_checker (
    .clk        (clk),
    .rst        (rst),
    .sample_mon (sample_bus),
    .result_mon (result_bus),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .pready     (pready),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .errors     (errors),
    .pending    (pending)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Run limit, counted in clock cycles.
  initial begin : watchdog
    int unsigned cycle_count;
    cycle_count = 0;
    while (cycle_count < CycleLimit) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("tb failed");
    $finish;
  end

  // Result receiver: random stalls, plus one long hold-off when requested.
  initial begin : receiver
    int   hold_left;
    logic hold_taken;
    hold_left  = 0;
    hold_taken = 1'b0;
    result_bus.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_request && !hold_taken) begin
        hold_taken = 1'b1;
        hold_left  = LongHold;
      end
      if (hold_left > 0) begin
        hold_left--;
        result_bus.ready <= 1'b0;
      end else begin
        result_bus.ready <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  // Offers one transaction and returns at the falling edge after it was taken.
  task automatic offer_sample(input logic op, input logic [DataW-1:0] stamp,
                              input logic [DataW-1:0] level);
    while ($urandom_range(99) < send_idle_pct) begin
      sample_bus.valid <= 1'b0;
      @(negedge clk);
    end
    sample_bus.valid        <= 1'b1;
    sample_bus.cmd          <= op;
    sample_bus.sample_time  <= stamp;
    sample_bus.sample_value <= level;
    @(posedge clk);
    while (!sample_bus.ready) begin
      @(posedge clk);
    end
    @(negedge clk);
  endtask

  // APB write: setup phase, access phase, then a quiet phase with psel low.
  task automatic write_register(input logic [AddrW-3:0] index, input logic [DataW-1:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {index, 2'b00};
    pwdata  <= data;
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) begin
      @(posedge clk);
    end
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(negedge clk);
  endtask

  // Waits until every predicted result has arrived and a trailing clear has settled.
  task automatic wait_drained();
    sample_bus.valid <= 1'b0;
    while (pending != 0) begin
      @(negedge clk);
    end
    repeat (DrainCycles) @(negedge clk);
  endtask

  // Mostly a smooth random walk with small time steps, plus clears, jumps and
  // time steps that are zero or negative.
  task automatic random_sample();
    int               pick;
    int               span;
    logic [DataW-1:0] stamp;
    logic [DataW-1:0] level;
    pick = $urandom_range(99);
    if (pick < 5) begin
      offer_sample(CmdClear, $urandom, $urandom);
    end else begin
      if (pick < 10) begin
        stamp = $urandom;
        level = $urandom;
      end else if (pick < 15) begin
        stamp = gen_time - DataW'($urandom_range(0, 3));
        level = $urandom;
      end else if (pick < 20) begin
        stamp = gen_time + $urandom;
        level = gen_value + $urandom;
      end else begin
        span  = $urandom_range(2, 24);
        stamp = gen_time + DataW'($urandom_range(1, 1 << $urandom_range(0, 6)));
        level = gen_value + DataW'($urandom_range(0, 1 << span)) - DataW'(1 << (span - 1));
      end
      offer_sample(CmdPush, stamp, level);
      gen_time  = stamp;
      gen_value = level;
    end
  endtask

  initial begin : stimulus
    int               seg;
    int               n;
    logic [DataW-1:0] thr_value;
    rst                     = 1'b1;
    sample_bus.valid        = 1'b0;
    sample_bus.cmd          = CmdPush;
    sample_bus.sample_time  = '0;
    sample_bus.sample_value = '0;
    psel          = 1'b0;
    penable       = 1'b0;
    pwrite        = 1'b0;
    paddr         = '0;
    pwdata        = '0;
    send_idle_pct = 25;
    recv_idle_pct = 60;
    hold_request  = 1'b0;
    gen_time      = '0;
    gen_value     = '0;
    repeat (8) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Directed part at the reset threshold: first sample, rate only, then curvature
    // on both sides of the threshold and exactly on it, with unit time steps.
    offer_sample(CmdPush, 32'd100, 32'd0);
    offer_sample(CmdPush, 32'd110, 32'd655360);
    offer_sample(CmdClear, '1, '1);
    offer_sample(CmdPush, 32'd200, 32'd0);
    offer_sample(CmdPush, 32'd201, 32'd1000);
    offer_sample(CmdPush, 32'd202, 32'd2655);
    offer_sample(CmdPush, 32'd203, 32'd4966);
    offer_sample(CmdPush, 32'd204, 32'd6622);
    offer_sample(CmdPush, 32'd205, 32'd7622);
    // Zero and negative time steps, then a rate against the kept previous rate.
    offer_sample(CmdPush, 32'd205, 32'd123);
    offer_sample(CmdPush, 32'd100, 32'd5);
    offer_sample(CmdPush, 32'd101, 32'd2005);
    // Saturation of the rate in both directions and of the curvature downwards, and the widest time steps.
    offer_sample(CmdClear, '0, '0);
    offer_sample(CmdPush, IntMin, IntMin);
    offer_sample(CmdPush, IntMin + 32'd1, IntMax);
    offer_sample(CmdPush, IntMin + 32'd2, IntMin);
    offer_sample(CmdPush, IntMax, IntMax);
    offer_sample(CmdPush, IntMin, 32'd0);
    offer_sample(CmdPush, IntMax, IntMin);
    offer_sample(CmdPush, IntMax - 32'd1, IntMax);
    offer_sample(CmdClear, '0, '1);
    offer_sample(CmdPush, '1, '0);
    offer_sample(CmdPush, 32'd0, IntMax);

    // Random segments, each under its own threshold; the idle pattern changes every four segments.
    for (seg = 0; seg < Segments; seg++) begin
      if (seg < 4) begin
        send_idle_pct = 25;
        recv_idle_pct = 60;
      end else if (seg < 8) begin
        send_idle_pct = 60;
        recv_idle_pct = 25;
      end else begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      wait_drained();
      if (seg == 0) begin
        thr_value = '0;
      end else if (seg == 1) begin
        thr_value = '1;
      end else begin
        thr_value = DataW'($urandom_range(0, 1 << $urandom_range(0, 22)));
      end
      write_register(RegAccelThreshold, thr_value);
      if (seg == 2) begin
        write_register(RegUnmapped, 32'd1);
      end
      if (seg == 8) begin
        hold_request <= 1'b1;
      end
      for (n = 0; n < SegmentLen; n++) begin
        random_sample();
      end
    end

    wait_drained();
    if (errors == 0) begin
      $display("tb passed");
    end else begin
      $display("tb failed");
    end
    $finish;
  end

endmodule
